// ===== hdl/scuf_pkg.sv =====
`timescale 1ns / 1ps

package scuf_pkg;

   localparam int HEADER_BYTES_DEFAULT = 37;

   // opcode field codes
   localparam logic OP_DATA = 1'b0;
   localparam logic OP_END  = 1'b1;

   // byte values the matcher looks at
   localparam logic [7:0] BYTE_ZERO     = 8'h00;
   localparam logic [7:0] BYTE_ONE      = 8'h01;
   localparam logic [7:0] BYTE_EMULATE  = 8'h03;
   localparam logic [7:0] SC_SLICE      = 8'h0B;
   localparam logic [7:0] SC_FIELD      = 8'h0C;
   localparam logic [7:0] SC_FRAME      = 8'h0D;

   typedef enum logic [1:0] {
      MATCH_NONE      = 2'd0,
      MATCH_ONE_ZERO  = 2'd1,
      MATCH_TWO_ZEROS = 2'd2,
      MATCH_ONE       = 2'd3
   } match_type;

   typedef struct packed {
      logic       opcode;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic       header_byte_valid;
      logic [7:0] header_byte;
      logic [5:0] header_position;
      logic       header_ready;
      logic [7:0] header_kind;
      logic [5:0] header_length;
      logic       sc_detected;
      logic [7:0] start_code_suffix;
      logic       frame_boundary;
      logic       picture_open;
   } rsp_type;

endpackage

// ===== hdl/scuf_stream_if.sv =====
`timescale 1ns / 1ps

interface scuf_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/scuf_matcher.sv =====
`timescale 1ns / 1ps

module scuf_matcher #(
   parameter int HEADER_BYTES = scuf_pkg::HEADER_BYTES_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  scuf_pkg::req_type req_item,
   output scuf_pkg::rsp_type rsp_item
);

   localparam int CountWidth = $clog2(HEADER_BYTES + 1);
   localparam logic [CountWidth-1:0] CountLimit = CountWidth'(HEADER_BYTES);

   scuf_pkg::match_type   match_ff, match_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic [7:0]            kind_ff, kind_in;
   logic                  picture_ff, picture_in;

   logic                  capturing;
   logic                  keep;
   logic                  found;
   logic [CountWidth+5:0] count_wide;
   logic [CountWidth+5:0] count_in_wide;
   logic [7:0]            data;

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff   <= scuf_pkg::MATCH_NONE;
         count_ff   <= '0;
         kind_ff    <= '0;
         picture_ff <= 1'b0;
      end else if (accept) begin
         match_ff   <= match_in;
         count_ff   <= count_in;
         kind_ff    <= kind_in;
         picture_ff <= picture_in;
      end
   end

   always_comb begin
      data          = req_item.data_byte;
      match_in      = match_ff;
      count_in      = count_ff;
      kind_in       = kind_ff;
      picture_in    = picture_ff;
      rsp_item      = '0;
      keep          = 1'b1;
      found         = 1'b0;
      capturing     = (count_ff < CountLimit);
      count_wide    = {6'd0, count_ff};
      count_in_wide = '0;

      if (req_item.opcode == scuf_pkg::OP_END) begin
         if (picture_ff) begin
            rsp_item.header_ready   = 1'b1;
            rsp_item.header_kind    = kind_ff;
            rsp_item.header_length  = count_wide[5:0];
            rsp_item.frame_boundary = 1'b1;
         end
      end else begin
         unique case (match_ff)
            scuf_pkg::MATCH_ONE: begin
               found    = 1'b1;
               match_in = scuf_pkg::MATCH_NONE;
            end
            scuf_pkg::MATCH_TWO_ZEROS: begin
               if (data == scuf_pkg::BYTE_ONE) begin
                  match_in = scuf_pkg::MATCH_ONE;
               end else if (data != scuf_pkg::BYTE_ZERO) begin
                  match_in = scuf_pkg::MATCH_NONE;
                  // emulation prevention byte, only dropped while capturing
                  if (data == scuf_pkg::BYTE_EMULATE) begin
                     keep = 1'b0;
                  end
               end
            end
            scuf_pkg::MATCH_ONE_ZERO: begin
               match_in = (data == scuf_pkg::BYTE_ZERO) ? scuf_pkg::MATCH_TWO_ZEROS
                                                        : scuf_pkg::MATCH_NONE;
            end
            scuf_pkg::MATCH_NONE: begin
               match_in = (data == scuf_pkg::BYTE_ZERO) ? scuf_pkg::MATCH_ONE_ZERO
                                                        : scuf_pkg::MATCH_NONE;
            end
            default: begin
               match_in = scuf_pkg::MATCH_NONE;
            end
         endcase

         if (capturing && keep) begin
            rsp_item.header_byte_valid = 1'b1;
            rsp_item.header_byte       = data;
            rsp_item.header_position   = count_wide[5:0];
            count_in                   = count_ff + CountWidth'(1);
         end

         if (found) begin
            // suffix byte counts toward the finished header
            count_in_wide              = {6'd0, count_in};
            rsp_item.header_ready      = 1'b1;
            rsp_item.header_kind       = kind_ff;
            rsp_item.header_length     = count_in_wide[5:0];
            rsp_item.sc_detected       = 1'b1;
            rsp_item.start_code_suffix = data;
            kind_in                    = data;
            count_in                   = '0;
            if (!picture_ff && (data == scuf_pkg::SC_FRAME || data == scuf_pkg::SC_FIELD)) begin
               picture_in = 1'b1;
            end else if (picture_ff && data != scuf_pkg::SC_FIELD
                         && data != scuf_pkg::SC_SLICE) begin
               rsp_item.frame_boundary = 1'b1;
               picture_in              = (data == scuf_pkg::SC_FRAME);
            end
         end
      end

      rsp_item.picture_open = picture_in;
   end

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountLimit)
      else $error("capture count beyond header size");

   a_found_reports_header: assert property (@(posedge clock) disable iff (reset)
      rsp_item.sc_detected |-> rsp_item.header_ready)
      else $error("start code without finished header");

   a_picture_holds_when_idle: assert property (@(posedge clock) disable iff (reset)
      (!accept && !reset) |=> $stable(picture_ff))
      else $error("picture state moved without a beat");

   a_found_clears_count: assert property (@(posedge clock) disable iff (reset)
      (accept && rsp_item.sc_detected) |=> (count_ff == '0
                                            && match_ff == scuf_pkg::MATCH_NONE))
      else $error("start code did not restart capture");

endmodule

// ===== hdl/scuf_out_skid.sv =====
`timescale 1ns / 1ps

module scuf_out_skid (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  scuf_pkg::rsp_type in_item,
   output logic              out_valid,
   input  logic              out_ready,
   output scuf_pkg::rsp_type out_item
);

   logic              out_valid_ff;
   logic              skid_valid_ff;
   scuf_pkg::rsp_type out_ff;
   scuf_pkg::rsp_type skid_ff;
   logic              take;
   logic              push;

   assign in_ready  = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_item  = out_ff;
   assign take      = out_valid_ff && out_ready;
   assign push      = in_valid && in_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (take) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (out_valid_ff && !take) begin
            skid_valid_ff <= 1'b1;
         end else begin
            out_valid_ff <= 1'b1;
         end
      end else if (take) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (take) begin
            out_ff <= skid_ff;
         end
      end else if (push) begin
         if (out_valid_ff && !take) begin
            skid_ff <= in_item;
         end else begin
            out_ff <= in_item;
         end
      end
   end

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry without output entry");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && take) |=> (!skid_valid_ff && out_valid_ff))
      else $error("skid entry lost on drain");

   a_stall_fills_skid: assert property (@(posedge clock) disable iff (reset)
      (push && out_valid_ff && !take) |=> skid_valid_ff)
      else $error("beat dropped while output stalled");

endmodule

// ===== hdl/start_code_scan_unescape_framer_top.sv =====
`timescale 1ns / 1ps

// channel    modport  beat contents
// req_chan   sink     opcode, data_byte
// rsp_chan   source   header byte, finished header, start code, frame flags
//
// one beat accepted per cycle while req_chan is ready; each beat gives one registered result beat
// the matcher and capture counter compute their next state combinationally
// between the input port and the output register
// reset clears the matcher, capture count, header kind and picture flag
// an output register plus one skid entry keep req_chan ready for one beat
// after rsp_chan stalls; ready drops only while both are full

module start_code_scan_unescape_framer_top #(
   parameter int HEADER_BYTES = scuf_pkg::HEADER_BYTES_DEFAULT
) (
   input logic         clock,
   input logic         reset,
   scuf_stream_if.sink   req_chan,
   scuf_stream_if.source rsp_chan
);

   scuf_pkg::req_type req_item;
   scuf_pkg::rsp_type rsp_item;
   scuf_pkg::rsp_type out_item;
   logic              accept;

   assign req_item         = req_chan.payload;
   assign accept           = req_chan.valid && req_chan.ready;
   assign rsp_chan.payload = out_item;

   scuf_matcher #(
      .HEADER_BYTES(HEADER_BYTES)
   ) u_matcher (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .req_item(req_item),
      .rsp_item(rsp_item)
   );

   scuf_out_skid u_out_skid (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_chan.valid),
      .in_ready (req_chan.ready),
      .in_item  (rsp_item),
      .out_valid(rsp_chan.valid),
      .out_ready(rsp_chan.ready),
      .out_item (out_item)
   );

endmodule

// ===== test/scuf_header_checker.sv =====
`timescale 1ns / 1ps

module scuf_header_checker #(
   parameter int HEADER_BYTES = scuf_pkg::HEADER_BYTES_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  scuf_pkg::req_type req_payload,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  scuf_pkg::rsp_type rsp_payload,
   output int                error_count,
   output int                pending_count
);

   // scanner state mirrored from the block
   scuf_pkg::match_type scan_state    = scuf_pkg::MATCH_NONE;
   int                  header_count  = 0;
   logic [7:0]          header_suffix = 8'h00;
   logic                picture_flag  = 1'b0;

   scuf_pkg::rsp_type predicted_rsp[$];
   int                mismatches = 0;
   int                rsp_seen   = 0;

   assign error_count = mismatches;

   function automatic scuf_pkg::rsp_type scan_beat(scuf_pkg::req_type beat);
      scuf_pkg::rsp_type r;
      logic [7:0]        b;
      logic              capturing;
      logic              kept;
      logic              found;
      r         = '0;
      b         = beat.data_byte;
      capturing = (header_count < HEADER_BYTES);
      kept      = 1'b1;
      found     = 1'b0;
      if (beat.opcode == scuf_pkg::OP_END) begin
         if (picture_flag) begin
            r.header_ready   = 1'b1;
            r.header_kind    = header_suffix;
            r.header_length  = header_count[5:0];
            r.frame_boundary = 1'b1;
         end
      end else begin
         case (scan_state)
            scuf_pkg::MATCH_ONE: begin
               found      = 1'b1;
               scan_state = scuf_pkg::MATCH_NONE;
            end
            scuf_pkg::MATCH_TWO_ZEROS: begin
               if (b == scuf_pkg::BYTE_ONE) begin
                  scan_state = scuf_pkg::MATCH_ONE;
               end else if (b != scuf_pkg::BYTE_ZERO) begin
                  // emulation prevention only applies while capturing
                  if (capturing && b == scuf_pkg::BYTE_EMULATE)
                     kept = 1'b0;
                  scan_state = scuf_pkg::MATCH_NONE;
               end
            end
            default: begin
               scan_state = (b == scuf_pkg::BYTE_ZERO)
                            ? scuf_pkg::match_type'(scan_state + 2'd1)
                            : scuf_pkg::MATCH_NONE;
            end
         endcase
         if (capturing && kept) begin
            r.header_byte_valid = 1'b1;
            r.header_byte       = b;
            r.header_position   = header_count[5:0];
            header_count++;
         end
         if (found) begin
            r.header_ready      = 1'b1;
            r.header_kind       = header_suffix;
            r.header_length     = header_count[5:0];
            r.sc_detected       = 1'b1;
            r.start_code_suffix = b;
            header_suffix       = b;
            header_count        = 0;
            if (!picture_flag && (b == scuf_pkg::SC_FRAME || b == scuf_pkg::SC_FIELD)) begin
               picture_flag = 1'b1;
            end else if (picture_flag && b != scuf_pkg::SC_FIELD
                         && b != scuf_pkg::SC_SLICE) begin
               r.frame_boundary = 1'b1;
               picture_flag     = (b == scuf_pkg::SC_FRAME);
            end
         end
      end
      r.picture_open = picture_flag;
      return r;
   endfunction

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10)
            $display("result %0d: %s expected %0h, got %0h", rsp_seen, name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      scuf_pkg::rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (predicted_rsp.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result %0d: unexpected beat %h", rsp_seen, rsp_payload);
            end else begin
               want = predicted_rsp.pop_front();
               check_field("header_byte_valid", want.header_byte_valid,
                           rsp_payload.header_byte_valid);
               check_field("header_byte", want.header_byte, rsp_payload.header_byte);
               check_field("header_position", want.header_position,
                           rsp_payload.header_position);
               check_field("header_ready", want.header_ready, rsp_payload.header_ready);
               check_field("header_kind", want.header_kind, rsp_payload.header_kind);
               check_field("header_length", want.header_length, rsp_payload.header_length);
               check_field("sc_detected", want.sc_detected,
                           rsp_payload.sc_detected);
               check_field("start_code_suffix", want.start_code_suffix,
                           rsp_payload.start_code_suffix);
               check_field("frame_boundary", want.frame_boundary,
                           rsp_payload.frame_boundary);
               check_field("picture_open", want.picture_open, rsp_payload.picture_open);
            end
            rsp_seen++;
         end
         if (req_valid && req_ready)
            predicted_rsp.push_back(scan_beat(req_payload));
         pending_count <= predicted_rsp.size();
      end
   end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;

   logic clock;
   logic reset = 1'b1;

   int   error_count;
   int   pending_count;
   int   sent_count      = 0;
   bit   quiet_mode      = 1'b0;
   int   hold_cycles_req = 0;

   scuf_stream_if #(.payload_type(scuf_pkg::req_type)) req_chan ();
   scuf_stream_if #(.payload_type(scuf_pkg::rsp_type)) rsp_chan ();

   start_code_scan_unescape_framer_top i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   scuf_header_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_chan.valid),
      .req_ready     (req_chan.ready),
      .req_payload   (req_chan.payload),
      .rsp_valid     (rsp_chan.valid),
      .rsp_ready     (rsp_chan.ready),
      .rsp_payload   (rsp_chan.payload),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   initial begin
      #10_000_000;
      $display("FAIL");
      $finish;
   end

   // result side: random stalls plus one long hold-off on request
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_cycles_req != 0) begin
            hold_left       = hold_cycles_req;
            hold_cycles_req = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= quiet_mode || ($urandom_range(99) >= 21);
         end
      end
   end

   task automatic send_beat(input logic op, input logic [7:0] b);
      scuf_pkg::req_type beat;
      beat.opcode    = op;
      beat.data_byte = b;
      while (!quiet_mode && $urandom_range(99) < 21) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.payload <= beat;
      do
         @(posedge clock);
      while (!req_chan.ready);
      sent_count++;
   endtask

   task automatic send_byte(input logic [7:0] b);
      send_beat(scuf_pkg::OP_DATA, b);
   endtask

   task automatic send_end();
      send_beat(scuf_pkg::OP_END, 8'($urandom_range(255)));
   endtask

   task automatic send_start_code(input logic [7:0] suffix);
      send_byte(scuf_pkg::BYTE_ZERO);
      send_byte(scuf_pkg::BYTE_ZERO);
      send_byte(scuf_pkg::BYTE_ONE);
      send_byte(suffix);
   endtask

   // the first wait lets the checker count the beat accepted last
   task automatic drain_results();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0)
         @(posedge clock);
   endtask

   // header body bytes lean on zeros, ones and emulation bytes
   function automatic logic [7:0] pick_body_byte();
      int r;
      r = $urandom_range(99);
      if (r < 30)
         return scuf_pkg::BYTE_ZERO;
      else if (r < 38)
         return scuf_pkg::BYTE_ONE;
      else if (r < 46)
         return scuf_pkg::BYTE_EMULATE;
      return 8'($urandom_range(255));
   endfunction

   function automatic logic [7:0] pick_suffix();
      int r;
      r = $urandom_range(99);
      if (r < 25)
         return scuf_pkg::SC_FRAME;
      else if (r < 40)
         return scuf_pkg::SC_FIELD;
      else if (r < 60)
         return scuf_pkg::SC_SLICE;
      return 8'($urandom_range(255));
   endfunction

   task automatic send_random_unit();
      int pick;
      int body_len;
      pick = $urandom_range(99);
      if (pick < 8) begin
         send_end();
         if ($urandom_range(3) == 0)
            send_end();
      end else if (pick < 20) begin
         // broken prefixes and plain noise
         send_byte(scuf_pkg::BYTE_ZERO);
         if ($urandom_range(1))
            send_byte(scuf_pkg::BYTE_ZERO);
         repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(255)));
      end else begin
         send_byte(scuf_pkg::BYTE_ZERO);
         send_byte(scuf_pkg::BYTE_ZERO);
         if ($urandom_range(9) == 0)
            send_byte(scuf_pkg::BYTE_ZERO);
         send_byte(scuf_pkg::BYTE_ONE);
         send_byte(pick_suffix());
         body_len = ($urandom_range(3) == 0) ? $urandom_range(30, 60) : $urandom_range(0, 12);
         repeat (body_len) send_byte(pick_body_byte());
      end
   endtask

   initial begin
      bit hold_done;
      bit drain_done;
      hold_done  = 1'b0;
      drain_done = 1'b0;
      req_chan.valid   <= 1'b0;
      req_chan.payload <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // bytes ahead of the first start code form a kind 0 header
      send_byte(8'hFF);
      send_byte(scuf_pkg::BYTE_ZERO);
      // end of stream with no picture open
      send_end();
      // emulation byte dropped
      send_byte(scuf_pkg::BYTE_ZERO);
      send_byte(scuf_pkg::BYTE_ZERO);
      send_byte(scuf_pkg::BYTE_EMULATE);
      // frame start opens a picture
      send_start_code(scuf_pkg::SC_FRAME);
      // extra leading zero, field start inside a picture
      send_byte(scuf_pkg::BYTE_ZERO);
      send_start_code(scuf_pkg::SC_FIELD);
      // end of stream with a picture open, repeated
      send_end();
      send_end();
      send_start_code(scuf_pkg::SC_SLICE);
      send_start_code(scuf_pkg::SC_FRAME);
      // other suffix closes the picture
      send_start_code(8'h0F);
      send_end();
      drain_results();

      while (sent_count < 1700) begin
         quiet_mode = (sent_count >= 700 && sent_count < 1000);
         if (!hold_done && sent_count >= 1100) begin
            hold_cycles_req = 80;
            hold_done       = 1'b1;
         end
         if (!drain_done && sent_count >= 1400) begin
            drain_results();
            drain_done = 1'b1;
         end
         send_random_unit();
      end

      quiet_mode = 1'b0;
      drain_results();
      repeat (10) @(posedge clock);
      if (error_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/scuf_pkg.sv
hdl/scuf_stream_if.sv
hdl/scuf_matcher.sv
hdl/scuf_out_skid.sv
hdl/start_code_scan_unescape_framer_top.sv
test/scuf_header_checker.sv
test/tb.sv
